>>> rtl/assert_macros.svh
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scl assertion failed");

// next-cycle implication, disabled while in reset
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scl assertion failed");

`endif

>>> rtl/scl_pkg.sv
// shared types and constants of the sphere cell list
`default_nettype none

package scl_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_NB,
		ST_ADDR1,
		ST_ADDR2,
		ST_HEAD,
		ST_RDS,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_CMP,
		ST_NEXT,
		ST_DONE
	} scl_state_t;

	// request kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// configuration register indexes
	localparam logic REG_CELLS  = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	// periodic image shift codes
	typedef logic [1:0] scl_shift_t;
	localparam scl_shift_t SH_NONE = 2'd0;
	localparam scl_shift_t SH_NEG  = 2'd1;
	localparam scl_shift_t SH_POS  = 2'd2;

	// neighbour offset codes
	typedef logic [1:0] scl_off_t;
	localparam scl_off_t OFF_MINUS = 2'd0;
	localparam scl_off_t OFF_ZERO  = 2'd1;
	localparam scl_off_t OFF_PLUS  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/scl_ram.sv
// single-port-write, registered-read synchronous memory
`default_nettype none

module scl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/scl_dist.sv
// one axis of the periodic distance: offset and registered square
`default_nettype none

module scl_dist
	import scl_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [COORD_BITS-1:0]     p,
	input  wire logic [COORD_BITS-1:0]     c,
	input  wire scl_shift_t                sh,
	output logic      [2*COORD_BITS+1:0]   sq
);

	localparam int DW = COORD_BITS + 2;

	logic signed [DW-1:0] d;
	logic signed [DW-1:0] adj;
	logic        [DW-2:0] ad;

	always_comb begin
		case (sh)
			SH_NEG:  adj = signed'(DW'(1) <<< COORD_BITS);
			SH_POS:  adj = -signed'(DW'(1) <<< COORD_BITS);
			default: adj = '0;
		endcase
		d  = signed'({2'b00, p}) - signed'({2'b00, c}) + adj;
		ad = d[DW-1] ? (DW-1)'(-d) : d[DW-2:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq <= (2*COORD_BITS+2)'(ad) * (2*COORD_BITS+2)'(ad);
		end
	end

endmodule

`default_nettype wire

>>> rtl/sphere_cell_list_point_cover.sv
// sphere cell list: periodic unit-cube grid of spheres with point-cover queries
// channels: in (valid/ready) carries insert or query requests; out (valid/ready)
// carries one covered flag per query, none per insert. cfg_we writes cells_per_axis
// (index 0) or radius_squared (index 1); the user must write them only while idle, unchecked.
// an insert steps through home cell, cell select, two steps of cell address
// arithmetic ending in the head memory read, then head and sphere memory
// writes.
// a query visits up to 27 neighbour cells; each sphere on a cell's chain costs
// a sphere memory read, three axis squares and a compare; it stops at the
// first covering sphere. the chain walk sets the rate.
// the flag sits in an output register; a new request is taken while it waits,
// and a finished query holds in its last step until that register is free.
// after reset the head memory is cleared one cell a cycle, all MAX_CELLS_PER_AXIS^3
// cells (4096 by default), before the first request is accepted.
`default_nettype none
`include "assert_macros.svh"

module sphere_cell_list_point_cover
	import scl_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = 16,
	parameter int MAX_SPHERE_ID      = 1024,
	parameter int COORD_BITS         = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [31:0]                          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [$clog2(MAX_SPHERE_ID+1)-1:0]   sphere_id,
	input  wire logic [COORD_BITS-1:0]                x_coord,
	input  wire logic [COORD_BITS-1:0]                y_coord,
	input  wire logic [COORD_BITS-1:0]                z_coord,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      covered
);

	localparam int NW    = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int AXW   = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
	localparam int NCELL = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
	localparam int CLW   = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int NID   = MAX_SPHERE_ID + 1;
	localparam int IDW   = $clog2(NID);
	localparam int VW    = $clog2(NID + 1);
	localparam int HW    = 1 + IDW;
	localparam int SW    = 1 + IDW + 3 * COORD_BITS;
	localparam int SQW   = 2 * COORD_BITS + 2;
	localparam int ACCW  = SQW + 2;
	localparam int CMPW  = (ACCW > 32) ? ACCW : 32;
	localparam int PW    = COORD_BITS + NW;

	scl_state_t state_q, state_d;

	logic [4:0]              cells_q;
	logic [31:0]             radius_q;
	logic [NW-1:0]           n_w;
	logic [CLW-1:0]          clr_q;
	logic                    kind_q;
	logic [IDW-1:0]          id_q;
	logic [COORD_BITS-1:0]   p_q [3];
	logic [AXW-1:0]          home_q [3];
	logic [AXW-1:0]          home_w [3];
	scl_off_t                g_q [3];
	logic [AXW-1:0]          nc_q [3];
	logic [AXW-1:0]          nc_w [3];
	scl_shift_t              sh_q [3];
	scl_shift_t              sh_w [3];
	logic [CLW-1:0]          t_q;
	logic [CLW-1:0]          cell_w;
	logic [CLW-1:0]          cell_q;
	logic [IDW-1:0]          j_q;
	logic [VW-1:0]           visits_q;
	logic [ACCW-1:0]         acc_q;
	logic [ACCW-1:0]         total_w;
	logic                    hit_w;
	logic                    more_w;
	logic                    last_nb_w;
	logic                    hit_q;
	logic                    out_valid_q;
	logic                    covered_q;

	logic                    head_we, head_re;
	logic [CLW-1:0]          head_waddr;
	logic [HW-1:0]           head_wdata, head_rdata;
	logic                    head_v;
	logic [IDW-1:0]          head_id;
	logic                    sph_we, sph_re;
	logic [SW-1:0]           sph_wdata, sph_rdata;
	logic                    link_v;
	logic [IDW-1:0]          link_id;
	logic [COORD_BITS-1:0]   cen [3];
	logic                    sq_en;
	logic [COORD_BITS-1:0]   dp, dc;
	scl_shift_t              dsh;
	logic [SQW-1:0]          sq;
	logic                    accept;
	logic                    ignore_w;
	logic                    out_load;

	assign accept   = in_valid && in_ready;
	assign ignore_w = (kind == KIND_INSERT) && (32'(sphere_id) > 32'(MAX_SPHERE_ID));
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign covered   = covered_q;

	always_comb begin
		if (cells_q == 5'd0) begin
			n_w = NW'(1);
		end else if (32'(cells_q) > 32'(MAX_CELLS_PER_AXIS)) begin
			n_w = NW'(MAX_CELLS_PER_AXIS);
		end else begin
			n_w = NW'(cells_q);
		end
	end

	always_comb begin
		logic [PW-1:0] prod;
		logic [NW:0]   up;
		for (int k = 0; k < 3; k++) begin
			prod      = PW'(p_q[k]) * PW'(n_w);
			home_w[k] = AXW'(prod >> COORD_BITS);
		end
		for (int k = 0; k < 3; k++) begin
			up = (NW+1)'(home_q[k]) + (NW+1)'(1);
			case (g_q[k])
				OFF_MINUS: begin
					if (home_q[k] == '0) begin
						nc_w[k] = AXW'(n_w - NW'(1));
						sh_w[k] = SH_NEG;
					end else begin
						nc_w[k] = home_q[k] - AXW'(1);
						sh_w[k] = SH_NONE;
					end
				end
				OFF_PLUS: begin
					if (up >= (NW+1)'(n_w)) begin
						nc_w[k] = '0;
						sh_w[k] = SH_POS;
					end else begin
						nc_w[k] = AXW'(up);
						sh_w[k] = SH_NONE;
					end
				end
				default: begin
					nc_w[k] = home_q[k];
					sh_w[k] = SH_NONE;
				end
			endcase
		end
	end

	assign cell_w = CLW'(nc_q[0]) + CLW'(n_w) * t_q;

	assign head_v  = head_rdata[HW-1];
	assign head_id = head_rdata[IDW-1:0];
	assign link_v  = sph_rdata[SW-1];
	assign link_id = sph_rdata[SW-2 -: IDW];
	assign cen[0]  = sph_rdata[COORD_BITS-1:0];
	assign cen[1]  = sph_rdata[2*COORD_BITS-1:COORD_BITS];
	assign cen[2]  = sph_rdata[3*COORD_BITS-1:2*COORD_BITS];

	assign total_w = acc_q + ACCW'(sq);
	assign hit_w   = CMPW'(total_w) <= CMPW'(radius_q);
	assign more_w  = link_v && (32'(link_id) <= 32'(MAX_SPHERE_ID))
		&& ((VW+1)'(visits_q) + (VW+1)'(1) < (VW+1)'(NID));
	assign last_nb_w = (g_q[0] == OFF_PLUS) && (g_q[1] == OFF_PLUS) && (g_q[2] == OFF_PLUS);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CLW'(NCELL - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept && !ignore_w) state_d = ST_HOME;
			ST_HOME:  state_d = ST_NB;
			ST_NB:    state_d = ST_ADDR1;
			ST_ADDR1: state_d = ST_ADDR2;
			ST_ADDR2: state_d = ST_HEAD;
			ST_HEAD: begin
				if (kind_q == KIND_INSERT) begin
					state_d = ST_IDLE;
				end else if (head_v && (32'(head_id) <= 32'(MAX_SPHERE_ID))) begin
					state_d = ST_RDS;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_RDS:   state_d = ST_D0;
			ST_D0:    state_d = ST_D1;
			ST_D1:    state_d = ST_D2;
			ST_D2:    state_d = ST_CMP;
			ST_CMP: begin
				if (hit_w) begin
					state_d = ST_DONE;
				end else if (more_w) begin
					state_d = ST_RDS;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT:  state_d = last_nb_w ? ST_DONE : ST_NB;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		in_ready   = 1'b0;
		head_we    = 1'b0;
		head_re    = 1'b0;
		head_waddr = cell_q;
		head_wdata = {1'b1, id_q};
		sph_we     = 1'b0;
		sph_re     = 1'b0;
		sq_en      = 1'b0;
		dp         = p_q[0];
		dc         = cen[0];
		dsh        = sh_q[0];
		case (state_q)
			ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = '0;
			end
			ST_IDLE:  in_ready = 1'b1;
			ST_ADDR2: head_re = 1'b1;
			ST_HEAD: begin
				if (kind_q == KIND_INSERT) begin
					head_we = 1'b1;
					sph_we  = 1'b1;
				end
			end
			ST_RDS:   sph_re = 1'b1;
			ST_D0:    sq_en = 1'b1;
			ST_D1: begin
				sq_en = 1'b1;
				dp    = p_q[1];
				dc    = cen[1];
				dsh   = sh_q[1];
			end
			ST_D2: begin
				sq_en = 1'b1;
				dp    = p_q[2];
				dc    = cen[2];
				dsh   = sh_q[2];
			end
			default: begin
			end
		endcase
	end

	assign sph_wdata = {head_v, (head_v ? head_id : IDW'(0)), p_q[2], p_q[1], p_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cells_q     <= 5'd16;
			radius_q    <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CLW'(1);
			if (cfg_we) begin
				case (cfg_index)
					REG_CELLS:  cells_q  <= cfg_data[4:0];
					REG_RADIUS: radius_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) hit_q <= 1'b0;
			else if (state_q == ST_CMP && hit_w) hit_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			id_q   <= sphere_id;
			p_q[0] <= x_coord;
			p_q[1] <= y_coord;
			p_q[2] <= z_coord;
			for (int k = 0; k < 3; k++) begin
				g_q[k] <= (kind == KIND_QUERY) ? OFF_MINUS : OFF_ZERO;
			end
		end
		if (out_load) covered_q <= hit_q;
		case (state_q)
			ST_HOME: home_q <= home_w;
			ST_NB: begin
				nc_q <= nc_w;
				sh_q <= sh_w;
			end
			ST_ADDR1: t_q <= CLW'(nc_q[1]) + CLW'(nc_q[2]) * CLW'(n_w);
			ST_ADDR2: cell_q <= cell_w;
			ST_HEAD: begin
				j_q      <= head_id;
				visits_q <= '0;
			end
			ST_D1: acc_q <= ACCW'(sq);
			ST_D2: acc_q <= acc_q + ACCW'(sq);
			ST_CMP: begin
				j_q      <= link_id;
				visits_q <= visits_q + VW'(1);
			end
			ST_NEXT: begin
				if (g_q[0] != OFF_PLUS) begin
					g_q[0] <= g_q[0] + scl_off_t'(1);
				end else begin
					g_q[0] <= OFF_MINUS;
					if (g_q[1] != OFF_PLUS) begin
						g_q[1] <= g_q[1] + scl_off_t'(1);
					end else begin
						g_q[1] <= OFF_MINUS;
						g_q[2] <= g_q[2] + scl_off_t'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	scl_ram #(
		.WIDTH (HW),
		.DEPTH (NCELL)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (cell_w),
		.rdata (head_rdata)
	);

	scl_ram #(
		.WIDTH (SW),
		.DEPTH (NID)
	) u_sphere_ram (
		.clk   (clk),
		.we    (sph_we),
		.waddr (id_q),
		.wdata (sph_wdata),
		.re    (sph_re),
		.raddr (j_q),
		.rdata (sph_rdata)
	);

	scl_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk (clk),
		.en  (sq_en),
		.p   (dp),
		.c   (dc),
		.sh  (dsh),
		.sq  (sq)
	);

	`SCL_ASSERT_IMPL(a_no_req_in_clear, clk, arst_n, state_q == ST_CLEAR, !in_ready)
	`SCL_ASSERT_NEXT(a_req_starts, clk, arst_n, accept && !ignore_w, state_q == ST_HOME)
	`SCL_ASSERT_IMPL(a_result_from_done, clk, arst_n, out_valid_q && !$past(out_valid_q), $past(state_q == ST_DONE) && $past(kind_q == KIND_QUERY))
	`SCL_ASSERT_IMPL(a_visit_bound, clk, arst_n, state_q == ST_CMP, (VW+1)'(visits_q) < (VW+1)'(NID))

endmodule

`default_nettype wire
